@@ hdl/prq_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the priority ready-queue scheduler
// no dependencies
package prq_pkg;

    localparam int ID_W     = 6;
    localparam int PRIO_W   = 2;
    localparam int STATUS_W = 3;

    localparam int PRIORITY_LEVELS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF     = 16;

    localparam logic ACT_SCHEDULE   = 1'b0;
    localparam logic ACT_MAKE_READY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SWITCHED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POSTPONED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    typedef logic [ID_W-1:0]     pid_t;
    typedef logic [PRIO_W-1:0]   prio_t;
    typedef logic [STATUS_W-1:0] status_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } prq_cmd_t;

endpackage

@@ hdl/prq_in_if.sv @@
`timescale 1ns / 1ps
// request channel: valid/ready plus one scheduler request item
// depends on prq_pkg
interface prq_in_if import prq_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  action;
    pid_t  process_id;
    prio_t priority_req;
    logic  current_running;
    logic  postpone;

    modport source (
        output valid, action, process_id, priority_req, current_running, postpone,
        input  ready
    );
    modport sink (
        input  valid, action, process_id, priority_req, current_running, postpone,
        output ready
    );
endinterface

@@ hdl/prq_out_if.sv @@
`timescale 1ns / 1ps
// result channel: valid/ready plus one scheduler result item
// depends on prq_pkg
interface prq_out_if import prq_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    switch_needed;
    pid_t    next_process;
    pid_t    previous_process;
    status_t status;

    modport source (
        output valid, switch_needed, next_process, previous_process, status,
        input  ready
    );
    modport sink (
        input  valid, switch_needed, next_process, previous_process, status,
        output ready
    );
endinterface

@@ hdl/prq_ram.sv @@
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/prq_ctrl.sv @@
`timescale 1ns / 1ps
// scheduler controller: request/result handshake and two-step sequencing
// depends on prq_pkg
module prq_ctrl import prq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     request_valid,
    output logic     request_ready,
    output logic     result_valid,
    input  logic     result_ready,
    output prq_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign request_ready = (state_reg == S_IDLE);
    assign result_valid  = out_valid_reg;
    assign out_free      = !out_valid_reg || result_ready;

    always_comb
    begin
        cmd.capture    = request_valid && request_ready;
        cmd.commit     = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // ram data is ready here; wait only for room in the result register
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/prq_datapath.sv @@
`timescale 1ns / 1ps
// scheduler datapath: per-level ring pointers, id store, running process
// depends on prq_pkg and prq_ram
module prq_datapath import prq_pkg::*; #(
    parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  prq_cmd_t cmd,
    input  logic     action,
    input  pid_t     process_id,
    input  prio_t    priority_req,
    input  logic     current_running,
    input  logic     postpone,
    output logic     switch_needed,
    output pid_t     next_process,
    output pid_t     previous_process,
    output status_t  status
);

    localparam int LVL_W  = $clog2(PRIORITY_LEVELS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = PRIORITY_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(ENTRIES);

    typedef logic [LVL_W-1:0] lvl_t;
    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    ptr_t head_reg  [PRIORITY_LEVELS];
    ptr_t tail_reg  [PRIORITY_LEVELS];
    cnt_t count_reg [PRIORITY_LEVELS];

    pid_t running_reg;
    lvl_t run_lvl_reg;
    logic pending_reg;

    // captured item
    logic  action_reg;
    pid_t  pid_reg;
    lvl_t  prio_lvl_reg;
    logic  still_run_reg;
    logic  postpone_reg;
    logic  pop_found_reg;
    lvl_t  pop_lvl_reg;

    // result register
    logic    sw_out_reg;
    pid_t    next_out_reg;
    pid_t    prev_out_reg;
    status_t status_out_reg;

    logic  found_c;
    lvl_t  found_lvl_c;
    lvl_t  prio_lvl_c;
    logic [ADDR_W-1:0] raddr;
    pid_t  rdata;

    logic    push_en, pop_en, push_full, push_ok, sw_c, pending_next;
    lvl_t    push_lvl;
    pid_t    push_id;
    status_t status_c;
    pid_t    running_next;
    lvl_t    run_lvl_next;
    logic [ADDR_W-1:0] waddr;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    // highest non-empty level, searched from the lowest priority upward
    always_comb
    begin
        found_c     = 1'b0;
        found_lvl_c = '0;
        for (int l = PRIORITY_LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                found_c     = 1'b1;
                found_lvl_c = lvl_t'(l);
            end
        end
    end

    // levels beyond the configured range fall to the lowest one
    always_comb
    begin
        if (int'(priority_req) >= PRIORITY_LEVELS)
        begin
            prio_lvl_c = lvl_t'(PRIORITY_LEVELS - 1);
        end
        else
        begin
            prio_lvl_c = lvl_t'(priority_req);
        end
    end

    assign raddr = ADDR_W'(int'(found_lvl_c) * QUEUE_DEPTH + int'(head_reg[found_lvl_c]));

    prq_ram #(
        .WIDTH (ID_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.commit && push_ok),
        .waddr (waddr),
        .wdata (push_id),
        .re    (cmd.capture),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        push_en      = 1'b0;
        pop_en       = 1'b0;
        push_lvl     = prio_lvl_reg;
        push_id      = pid_reg;
        sw_c         = 1'b0;
        status_c     = ST_OK;
        pending_next = pending_reg;
        running_next = running_reg;
        run_lvl_next = run_lvl_reg;
        if (action_reg == ACT_MAKE_READY)
        begin
            push_en = 1'b1;
        end
        else if (postpone_reg)
        begin
            pending_next = 1'b1;
            status_c     = ST_POSTPONED;
        end
        else if (pending_reg)
        begin
            pending_next = 1'b0;
            status_c     = ST_CONFLICT;
        end
        else if (!pop_found_reg)
        begin
            status_c = still_run_reg ? ST_OK : ST_NONE;
        end
        else
        begin
            pop_en       = 1'b1;
            sw_c         = 1'b1;
            status_c     = ST_SWITCHED;
            running_next = rdata;
            run_lvl_next = pop_lvl_reg;
            if (still_run_reg)
            begin
                push_en  = 1'b1;
                push_lvl = run_lvl_reg;
                push_id  = running_reg;
            end
        end
        // a pop from the same level frees a slot before the requeue
        push_full = (count_reg[push_lvl] == cnt_t'(QUEUE_DEPTH))
                    && !(pop_en && (pop_lvl_reg == push_lvl));
        push_ok   = push_en && !push_full;
        if (push_en && push_full)
        begin
            status_c = ST_FULL;
        end
    end

    assign waddr = ADDR_W'(int'(push_lvl) * QUEUE_DEPTH + int'(tail_reg[push_lvl]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < PRIORITY_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            running_reg <= '0;
            run_lvl_reg <= lvl_t'(PRIORITY_LEVELS - 1);
            pending_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            for (int l = 0; l < PRIORITY_LEVELS; l++)
            begin
                if (pop_en && (pop_lvl_reg == lvl_t'(l)))
                begin
                    head_reg[l] <= ptr_inc(head_reg[l]);
                end
                if (push_ok && (push_lvl == lvl_t'(l)))
                begin
                    tail_reg[l] <= ptr_inc(tail_reg[l]);
                end
                count_reg[l] <= count_reg[l]
                    + cnt_t'(push_ok && (push_lvl == lvl_t'(l)))
                    - cnt_t'(pop_en && (pop_lvl_reg == lvl_t'(l)));
            end
            running_reg <= running_next;
            run_lvl_reg <= run_lvl_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg    <= action;
            pid_reg       <= process_id;
            prio_lvl_reg  <= prio_lvl_c;
            still_run_reg <= current_running;
            postpone_reg  <= postpone;
            pop_found_reg <= found_c;
            pop_lvl_reg   <= found_lvl_c;
        end
        if (cmd.commit)
        begin
            sw_out_reg     <= sw_c;
            next_out_reg   <= running_next;
            prev_out_reg   <= running_reg;
            status_out_reg <= status_c;
        end
    end

    assign switch_needed    = sw_out_reg;
    assign next_process     = next_out_reg;
    assign previous_process = prev_out_reg;
    assign status           = status_out_reg;

endmodule

@@ hdl/priority_ready_queue_scheduler.sv @@
`timescale 1ns / 1ps
// priority ready-queue scheduler, one fifo of process ids per level
// id store is read at request accept; result is registered at commit once the output is free
// the next request is taken only after the current one commits (registered id store read)
// a held result stalls the commit step, and no new request is taken meanwhile
// reset: asynchronous active-low, clears all queues, running id 0 at lowest level
// depends on prq_pkg, prq_in_if, prq_out_if, prq_ctrl, prq_datapath, prq_ram
module priority_ready_queue_scheduler import prq_pkg::*; #(
    parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    prq_in_if.sink      request,
    prq_out_if.source   result
);

    prq_cmd_t cmd;

    prq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request.valid),
        .request_ready (request.ready),
        .result_valid  (result.valid),
        .result_ready  (result.ready),
        .cmd           (cmd)
    );

    prq_datapath #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .action           (request.action),
        .process_id       (request.process_id),
        .priority_req     (request.priority_req),
        .current_running  (request.current_running),
        .postpone         (request.postpone),
        .switch_needed    (result.switch_needed),
        .next_process     (result.next_process),
        .previous_process (result.previous_process),
        .status           (result.status)
    );

endmodule
